// ----- hdl/lli_pkg.sv -----
// Shared constants and types for the line-line intersection block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package lli_pkg;

    // Default coordinate and result widths (Q8.8 in, Q24.8 out)
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int RESULT_WIDTH_DEF = 32;

    // Parallel threshold register
    localparam int               THRESH_WIDTH = 16;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 16'd1;

    // Output queue depth (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Lane numbers in the divider and saturation stages
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANES  = 2;

    // Control word that travels down the pipeline with each transaction
    typedef struct packed {
        logic             valid;
        logic             par;
        logic [LANES-1:0] neg;
    } lli_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/lli_if.sv -----
// Query and result channel interfaces for the line-line intersection block.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface lli_in_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] l1_ax;
    logic signed [COORD_WIDTH-1:0] l1_ay;
    logic signed [COORD_WIDTH-1:0] l1_bx;
    logic signed [COORD_WIDTH-1:0] l1_by;
    logic signed [COORD_WIDTH-1:0] l2_ax;
    logic signed [COORD_WIDTH-1:0] l2_ay;
    logic signed [COORD_WIDTH-1:0] l2_bx;
    logic signed [COORD_WIDTH-1:0] l2_by;

    modport source (
        output valid, l1_ax, l1_ay, l1_bx, l1_by, l2_ax, l2_ay, l2_bx, l2_by,
        input  ready
    );
    modport sink (
        input  valid, l1_ax, l1_ay, l1_bx, l1_by, l2_ax, l2_ay, l2_bx, l2_by,
        output ready
    );
endinterface

interface lli_out_if #(
    parameter int RESULT_WIDTH = 32
);
    logic                           valid;
    logic                           ready;
    logic                           intersects;
    logic signed [RESULT_WIDTH-1:0] cross_x;
    logic signed [RESULT_WIDTH-1:0] cross_y;
    logic                           saturated;

    modport source (
        output valid, intersects, cross_x, cross_y, saturated,
        input  ready
    );
    modport sink (
        input  valid, intersects, cross_x, cross_y, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/line_line_intersection.sv -----
// Line-line intersection, determinant method.
// query channel: two lines as two points each, signed fixed point
//   (COORD_WIDTH bits, Q8.8 at default). result channel: intersects flag,
//   cross_x / cross_y signed (RESULT_WIDTH bits, Q24.8 at default), and a
//   saturated flag. Both channels are valid/ready; a transaction completes
//   when both are high at a rising edge.
// Configuration: cfg_we / cfg_wdata write the parallel threshold; lines are
//   reported parallel when |determinant| is zero or below it (reset value 1). Write
//   only while the pipeline is empty.
// Throughput: one query per cycle while the output queue has room.
// Pipeline: seven front-end stages, one divider stage per quotient bit
//   (3*COORD_WIDTH+5 bits), two saturation stages, and the output queue.
// Stalls: a two-entry queue holds results; the whole pipeline halts only
//   when it is full, so nothing is lost or repeated, and a query is still
//   taken while one result waits.
// Reset clears every valid bit and the queue; the threshold returns to 1.
`timescale 1ns / 1ps
`default_nettype none

module line_line_intersection #(
    parameter int COORD_WIDTH  = lli_pkg::COORD_WIDTH_DEF,
    parameter int RESULT_WIDTH = lli_pkg::RESULT_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lli_pkg::THRESH_WIDTH-1:0]  cfg_wdata,
    lli_in_if.sink                                 query,
    lli_out_if.source                              result
);

    localparam int NQ_W  = 3 * COORD_WIDTH + 5;
    localparam int DEN_W = 2 * COORD_WIDTH + 4;
    localparam int Q_W   = 2 + 2 * RESULT_WIDTH;

    logic [lli_pkg::THRESH_WIDTH-1:0] thresh_reg;
    logic                             en;

    lli_pkg::lli_ctl_t       front_ctl, div_ctl;
    logic [NQ_W-1:0]         num [lli_pkg::LANES];
    logic [DEN_W-1:0]        den;
    logic [NQ_W-1:0]         quo [lli_pkg::LANES];

    logic                           sat_valid, sat_int, sat_flag;
    logic signed [RESULT_WIDTH-1:0] sat_x, sat_y;
    logic [Q_W-1:0]                 q_wdata, q_rdata;
    logic                           q_space, q_avail;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= lli_pkg::THRESH_RESET;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    // Pipeline advances whenever the output queue has room
    assign en          = q_space;
    assign query.ready = en;

    lli_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query.valid),
        .ax1       (query.l1_ax),
        .ay1       (query.l1_ay),
        .bx1       (query.l1_bx),
        .by1       (query.l1_by),
        .ax2       (query.l2_ax),
        .ay2       (query.l2_ay),
        .bx2       (query.l2_bx),
        .by2       (query.l2_by),
        .threshold (thresh_reg),
        .ctl       (front_ctl),
        .num_x     (num[lli_pkg::LANE_X]),
        .num_y     (num[lli_pkg::LANE_Y]),
        .den       (den)
    );

    lli_div #(
        .NQ_W  (NQ_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (front_ctl),
        .num_in  (num),
        .den_in  (den),
        .ctl_out (div_ctl),
        .q_out   (quo)
    );

    lli_sat #(
        .NQ_W         (NQ_W),
        .RESULT_WIDTH (RESULT_WIDTH)
    ) u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .ctl_in     (div_ctl),
        .q_in       (quo),
        .valid      (sat_valid),
        .intersects (sat_int),
        .cross_x    (sat_x),
        .cross_y    (sat_y),
        .saturated  (sat_flag)
    );

    // Output queue
    assign q_wdata = {sat_int, sat_flag, sat_x, sat_y};

    lli_outq #(
        .WIDTH (Q_W)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (sat_valid && en),
        .wdata (q_wdata),
        .space (q_space),
        .avail (q_avail),
        .pop   (q_avail && result.ready),
        .rdata (q_rdata)
    );

    assign result.valid      = q_avail;
    assign result.intersects = q_rdata[Q_W-1];
    assign result.saturated  = q_rdata[Q_W-2];
    assign result.cross_x    = q_rdata[2*RESULT_WIDTH-1:RESULT_WIDTH];
    assign result.cross_y    = q_rdata[RESULT_WIDTH-1:0];

    // Parallel lines report all-zero fields
    a_par_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.intersects) |->
            (result.cross_x == '0 && result.cross_y == '0 && !result.saturated))
        else $error("non-zero fields on parallel result");

    // Pipeline frozen while the queue is full
    a_hold_full : assert property (@(posedge clk) disable iff (!rst_n)
        !q_space |=> $stable(div_ctl))
        else $error("pipeline moved while output queue full");

endmodule

`default_nettype wire

// ----- hdl/lli_front.sv -----
// Front end: differences, products, determinant, parallel test and the
// rounded division operands. Seven register stages. Uses lli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lli_front #(
    parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic signed [COORD_WIDTH-1:0]      ax1,
    input  wire logic signed [COORD_WIDTH-1:0]      ay1,
    input  wire logic signed [COORD_WIDTH-1:0]      bx1,
    input  wire logic signed [COORD_WIDTH-1:0]      by1,
    input  wire logic signed [COORD_WIDTH-1:0]      ax2,
    input  wire logic signed [COORD_WIDTH-1:0]      ay2,
    input  wire logic signed [COORD_WIDTH-1:0]      bx2,
    input  wire logic signed [COORD_WIDTH-1:0]      by2,
    input  wire logic [lli_pkg::THRESH_WIDTH-1:0]   threshold,
    output lli_pkg::lli_ctl_t                       ctl,
    output logic [3*COORD_WIDTH+4:0]                num_x,
    output logic [3*COORD_WIDTH+4:0]                num_y,
    output logic [2*COORD_WIDTH+3:0]                den
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PP_W   = 2 * COORD_WIDTH;
    localparam int PD_W   = 2 * DIFF_W;
    localparam int AB_W   = 2 * COORD_WIDTH + 1;
    localparam int C_W    = 2 * COORD_WIDTH + 3;
    localparam int PN_W   = AB_W + DIFF_W;
    localparam int NUM_W  = 3 * COORD_WIDTH + 3;
    localparam int NQ_W   = NUM_W + 2;
    localparam int DEN_W  = C_W + 1;
    localparam int STAGES = 7;

    logic [STAGES-1:0] v_reg;

    // stage 1
    logic signed [DIFF_W-1:0] x12_1_reg, y12_1_reg, x34_1_reg, y34_1_reg;
    logic signed [PP_W-1:0]   pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    // stage 2
    logic signed [DIFF_W-1:0] x12_2_reg, y12_2_reg, x34_2_reg, y34_2_reg;
    logic signed [PD_W-1:0]   pc1_reg, pc2_reg;
    logic signed [AB_W-1:0]   a_2_reg, b_2_reg;
    // stage 3
    logic signed [DIFF_W-1:0] x12_3_reg, y12_3_reg, x34_3_reg, y34_3_reg;
    logic signed [C_W-1:0]    c_3_reg;
    logic signed [AB_W-1:0]   a_3_reg, b_3_reg;
    // stage 4
    logic                     cneg_4_reg;
    logic [C_W-1:0]           cm_4_reg;
    logic signed [PN_W-1:0]   ax34_reg, bx12_reg, ay34_reg, by12_reg;
    // stage 5
    logic                     cneg_5_reg, par_5_reg;
    logic [C_W-1:0]           cm_5_reg;
    logic signed [NUM_W-1:0]  nx_5_reg, ny_5_reg;
    // stage 6
    logic                     par_6_reg, negx_6_reg, negy_6_reg;
    logic [C_W-1:0]           cm_6_reg;
    logic [NUM_W-1:0]         nmx_6_reg, nmy_6_reg;
    // stage 7
    logic                     par_7_reg, negx_7_reg, negy_7_reg;
    logic [NQ_W-1:0]          numx_7_reg, numy_7_reg;
    logic [DEN_W-1:0]         den_7_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // differences and point cross products
            x12_1_reg <= DIFF_W'(ax1) - DIFF_W'(bx1);
            y12_1_reg <= DIFF_W'(ay1) - DIFF_W'(by1);
            x34_1_reg <= DIFF_W'(ax2) - DIFF_W'(bx2);
            y34_1_reg <= DIFF_W'(ay2) - DIFF_W'(by2);
            pa1_reg   <= ax1 * by1;
            pa2_reg   <= ay1 * bx1;
            pb1_reg   <= ax2 * by2;
            pb2_reg   <= ay2 * bx2;

            // determinant products, a and b
            x12_2_reg <= x12_1_reg;
            y12_2_reg <= y12_1_reg;
            x34_2_reg <= x34_1_reg;
            y34_2_reg <= y34_1_reg;
            pc1_reg   <= x12_1_reg * y34_1_reg;
            pc2_reg   <= y12_1_reg * x34_1_reg;
            a_2_reg   <= AB_W'(pa1_reg) - AB_W'(pa2_reg);
            b_2_reg   <= AB_W'(pb1_reg) - AB_W'(pb2_reg);

            // determinant
            x12_3_reg <= x12_2_reg;
            y12_3_reg <= y12_2_reg;
            x34_3_reg <= x34_2_reg;
            y34_3_reg <= y34_2_reg;
            c_3_reg   <= C_W'(pc1_reg) - C_W'(pc2_reg);
            a_3_reg   <= a_2_reg;
            b_3_reg   <= b_2_reg;

            // |c| and numerator products
            cneg_4_reg <= c_3_reg[C_W-1];
            cm_4_reg   <= c_3_reg[C_W-1] ? C_W'(-c_3_reg) : C_W'(c_3_reg);
            ax34_reg   <= a_3_reg * x34_3_reg;
            bx12_reg   <= b_3_reg * x12_3_reg;
            ay34_reg   <= a_3_reg * y34_3_reg;
            by12_reg   <= b_3_reg * y12_3_reg;

            // numerators and parallel test
            cneg_5_reg <= cneg_4_reg;
            cm_5_reg   <= cm_4_reg;
            par_5_reg  <= (cm_4_reg == '0) || (cm_4_reg < C_W'(threshold));
            nx_5_reg   <= NUM_W'(ax34_reg) - NUM_W'(bx12_reg);
            ny_5_reg   <= NUM_W'(ay34_reg) - NUM_W'(by12_reg);

            // numerator magnitudes and quotient signs
            par_6_reg  <= par_5_reg;
            cm_6_reg   <= cm_5_reg;
            negx_6_reg <= nx_5_reg[NUM_W-1] ^ cneg_5_reg;
            negy_6_reg <= ny_5_reg[NUM_W-1] ^ cneg_5_reg;
            nmx_6_reg  <= nx_5_reg[NUM_W-1] ? NUM_W'(-nx_5_reg) : NUM_W'(nx_5_reg);
            nmy_6_reg  <= ny_5_reg[NUM_W-1] ? NUM_W'(-ny_5_reg) : NUM_W'(ny_5_reg);

            // rounding: q = (2|n| + |c|) / (2|c|)
            par_7_reg  <= par_6_reg;
            negx_7_reg <= negx_6_reg;
            negy_7_reg <= negy_6_reg;
            numx_7_reg <= {1'b0, nmx_6_reg, 1'b0} + NQ_W'(cm_6_reg);
            numy_7_reg <= {1'b0, nmy_6_reg, 1'b0} + NQ_W'(cm_6_reg);
            den_7_reg  <= {cm_6_reg, 1'b0};
        end
    end

    // Outputs
    always_comb
    begin
        ctl.valid               = v_reg[STAGES-1];
        ctl.par                 = par_7_reg;
        ctl.neg[lli_pkg::LANE_X] = negx_7_reg;
        ctl.neg[lli_pkg::LANE_Y] = negy_7_reg;
    end

    assign num_x = numx_7_reg;
    assign num_y = numy_7_reg;
    assign den   = den_7_reg;

endmodule

`default_nettype wire

// ----- hdl/lli_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes
// sharing one divisor. Uses lli_pkg for the control word.
`timescale 1ns / 1ps
`default_nettype none

module lli_div #(
    parameter int NQ_W  = 53,
    parameter int DEN_W = 36
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire lli_pkg::lli_ctl_t  ctl_in,
    input  wire logic [NQ_W-1:0]    num_in [lli_pkg::LANES],
    input  wire logic [DEN_W-1:0]   den_in,
    output lli_pkg::lli_ctl_t       ctl_out,
    output logic [NQ_W-1:0]         q_out [lli_pkg::LANES]
);

    localparam int STAGES = NQ_W;

    lli_pkg::lli_ctl_t ctl_reg [STAGES];
    logic [DEN_W-1:0]  den_reg [STAGES];
    logic [DEN_W-1:0]  rem_reg [STAGES][lli_pkg::LANES];
    logic [NQ_W-1:0]   nq_reg  [STAGES][lli_pkg::LANES];

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        lli_pkg::lli_ctl_t ctl_src;
        logic [DEN_W-1:0]  den_src;
        logic [DEN_W-1:0]  rem_src  [lli_pkg::LANES];
        logic [NQ_W-1:0]   nq_src   [lli_pkg::LANES];
        logic [DEN_W-1:0]  rem_next [lli_pkg::LANES];
        logic [NQ_W-1:0]   nq_next  [lli_pkg::LANES];

        // stage input: ports for the first stage, previous stage otherwise
        if (k == 0)
        begin : g_first
            assign ctl_src = ctl_in;
            assign den_src = den_in;
            for (genvar l = 0; l < lli_pkg::LANES; l++)
            begin : g_lane
                assign rem_src[l] = '0;
                assign nq_src[l]  = num_in[l];
            end
        end
        else
        begin : g_next
            assign ctl_src = ctl_reg[k-1];
            assign den_src = den_reg[k-1];
            for (genvar l = 0; l < lli_pkg::LANES; l++)
            begin : g_lane
                assign rem_src[l] = rem_reg[k-1][l];
                assign nq_src[l]  = nq_reg[k-1][l];
            end
        end

        // one trial subtraction per lane; quotient bit shifts in at the bottom
        for (genvar l = 0; l < lli_pkg::LANES; l++)
        begin : g_trial
            logic [DEN_W:0] trial;
            logic           ge;
            assign trial       = {rem_src[l], nq_src[l][NQ_W-1]};
            assign ge          = trial >= {1'b0, den_src};
            assign rem_next[l] = ge ? DEN_W'(trial - {1'b0, den_src}) : DEN_W'(trial);
            assign nq_next[l]  = {nq_src[l][NQ_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (en)
            begin
                ctl_reg[k] <= ctl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k] <= den_src;
                for (int l = 0; l < lli_pkg::LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[l];
                    nq_reg[k][l]  <= nq_next[l];
                end
            end
        end
    end

    assign ctl_out = ctl_reg[STAGES-1];
    assign q_out   = nq_reg[STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/lli_sat.sv -----
// Sign restore and saturation of the two quotients, two register stages.
// Uses lli_pkg for the control word and lane numbers.
`timescale 1ns / 1ps
`default_nettype none

module lli_sat #(
    parameter int NQ_W         = 53,
    parameter int RESULT_WIDTH = lli_pkg::RESULT_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire lli_pkg::lli_ctl_t          ctl_in,
    input  wire logic [NQ_W-1:0]            q_in [lli_pkg::LANES],
    output logic                            valid,
    output logic                            intersects,
    output logic signed [RESULT_WIDTH-1:0]  cross_x,
    output logic signed [RESULT_WIDTH-1:0]  cross_y,
    output logic                            saturated
);

    localparam int CMP_W = ((NQ_W > RESULT_WIDTH) ? NQ_W : RESULT_WIDTH) + 1;
    localparam logic [CMP_W-1:0] HALF = CMP_W'(1) << (RESULT_WIDTH - 1);
    localparam logic [RESULT_WIDTH-1:0] MAG_MIN = {1'b1, {(RESULT_WIDTH-1){1'b0}}};
    localparam logic [RESULT_WIDTH-1:0] MAG_MAX = {1'b0, {(RESULT_WIDTH-1){1'b1}}};

    logic                    va_reg, par_a_reg;
    logic [lli_pkg::LANES-1:0] neg_a_reg, ov_a_reg;
    logic [RESULT_WIDTH-1:0] qc_a_reg [lli_pkg::LANES];

    logic                    vb_reg;
    logic                    int_b_reg, sat_b_reg;
    logic [RESULT_WIDTH-1:0] cx_b_reg, cy_b_reg;

    logic [lli_pkg::LANES-1:0] neg_eff, over;
    logic [RESULT_WIDTH-1:0]   qc_next [lli_pkg::LANES];
    logic [RESULT_WIDTH-1:0]   r_next  [lli_pkg::LANES];

    // Stage A: effective sign (zero is never negative) and clamp
    always_comb
    begin
        for (int l = 0; l < lli_pkg::LANES; l++)
        begin
            neg_eff[l] = ctl_in.neg[l] && (q_in[l] != '0);
            over[l]    = neg_eff[l] ? (CMP_W'(q_in[l]) > HALF)
                                    : (CMP_W'(q_in[l]) > (HALF - CMP_W'(1)));
            if (over[l])
            begin
                qc_next[l] = neg_eff[l] ? MAG_MIN : MAG_MAX;
            end
            else
            begin
                qc_next[l] = RESULT_WIDTH'(CMP_W'(q_in[l]));
            end
        end
    end

    // Stage B: apply the sign
    always_comb
    begin
        for (int l = 0; l < lli_pkg::LANES; l++)
        begin
            r_next[l] = neg_a_reg[l] ? (~qc_a_reg[l] + RESULT_WIDTH'(1)) : qc_a_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= ctl_in.valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_a_reg <= ctl_in.par;
            neg_a_reg <= neg_eff;
            ov_a_reg  <= over;
            qc_a_reg  <= qc_next;

            // parallel lines give all-zero results
            int_b_reg <= !par_a_reg;
            sat_b_reg <= !par_a_reg && (ov_a_reg != '0);
            cx_b_reg  <= par_a_reg ? '0 : r_next[lli_pkg::LANE_X];
            cy_b_reg  <= par_a_reg ? '0 : r_next[lli_pkg::LANE_Y];
        end
    end

    assign valid      = vb_reg;
    assign intersects = int_b_reg;
    assign saturated  = sat_b_reg;
    assign cross_x    = cx_b_reg;
    assign cross_y    = cy_b_reg;

    // A saturated result carries at least one clamped coordinate
    a_sat_clamped : assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && sat_b_reg) |->
            (cx_b_reg == MAG_MIN || cx_b_reg == MAG_MAX ||
             cy_b_reg == MAG_MIN || cy_b_reg == MAG_MAX))
        else $error("saturated flag without a clamped coordinate");

    // Saturation only ever accompanies an intersection
    a_sat_int : assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && sat_b_reg) |-> int_b_reg)
        else $error("saturated flag on parallel lines");

endmodule

`default_nettype wire

// ----- hdl/lli_outq.sv -----
// Two-entry output queue that decouples the pipeline from the receiver.
// Uses lli_pkg for the depth.
`timescale 1ns / 1ps
`default_nettype none

module lli_outq #(
    parameter int WIDTH = 66
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  space,
    output logic                  avail,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata
);

    localparam int DEPTH = lli_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign space = (count_reg != CNT_W'(DEPTH));
    assign avail = (count_reg != '0);
    assign rdata = mem[rd_ptr_reg];

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)))
        else $error("output queue overflow");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("output queue underflow");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("output queue count out of range");

endmodule

`default_nettype wire
